### rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants for the box filter downsampler
// Default sizes, register map, reset values and the control/status bundles
// passed between the position tracker, controller and datapath.
// ----------------------------------------------------------------------------
package bfd_pkg;

	// default sizes for the top-level parameters
	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int DEF_MAX_FACTOR   = 16;
	localparam int DEF_SAMPLE_BITS  = 16;

	// frame height limit is a fixed constant, not a top-level parameter
	localparam int MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;

	// register field widths
	localparam int BF_W   = 5;
	localparam int IW_W   = 13;
	localparam int IH_W   = 13;
	localparam int CCNT_W = 3;

	// output channel field width
	localparam int CHAN_OUT_W = 2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(3);

	// register reset values
	localparam logic [BF_W-1:0]   RST_BLOCK_FACTOR  = BF_W'(2);
	localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH   = IW_W'(4096);
	localparam logic [IH_W-1:0]   RST_IMAGE_HEIGHT  = IH_W'(4096);
	localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = CCNT_W'(4);

	// per-item flags from the position tracker
	typedef struct packed {
		logic first;   // first sample of its block: overwrite the band sum
		logic whole;   // sample lies in a whole block
		logic emit;    // last sample of a whole block
		logic done;    // that result closes the output frame
	} pos_flags_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic acc;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_busy;
	} dp_status_t;

endpackage

### rtl/bfd_pos.sv
// ----------------------------------------------------------------------------
// bfd_pos: configuration registers and raster position tracking
// Holds the four registers, clamps them, and keeps the channel, column,
// row and in-block counters plus the running block origin and band address.
// ----------------------------------------------------------------------------
module bfd_pos import bfd_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS),
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int FACT_W = $clog2(MAX_FACTOR + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  advance,
	output logic [ADDR_W-1:0]     addr,
	output logic [CH_W-1:0]       ch,
	output logic [FACT_W-1:0]     n,
	output pos_flags_t            flags
);

	localparam int CC_W      = $clog2(MAX_CHANNELS + 1);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int CIB_W     = $clog2(MAX_FACTOR);
	localparam int COL_EXT_W = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
	localparam int ROW_EXT_W = $clog2(MAX_HEIGHT + 2 * MAX_FACTOR + 1);

	logic [BF_W-1:0]   bf_q;
	logic [IW_W-1:0]   iw_q;
	logic [IH_W-1:0]   ih_q;
	logic [CCNT_W-1:0] cc_q;

	logic [CH_W-1:0]   ch_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_base_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_base_q;
	logic [CIB_W-1:0]  cib_q;
	logic [CIB_W-1:0]  rib_q;
	logic [ADDR_W-1:0] band_q;

	logic [COL_EXT_W-1:0] w;
	logic [ROW_EXT_W-1:0] h;
	logic [CC_W-1:0]      c;
	logic [COL_EXT_W-1:0] col_end;
	logic [ROW_EXT_W-1:0] row_end;
	logic                 cfg_known;
	logic                 last_ch, last_col, last_row, last_cib, last_rib;
	logic                 whole_col, whole_row, final_col, final_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q <= RST_BLOCK_FACTOR;
			iw_q <= RST_IMAGE_WIDTH;
			ih_q <= RST_IMAGE_HEIGHT;
			cc_q <= RST_CHANNEL_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLOCK_FACTOR:  bf_q <= cfg_data[BF_W-1:0];
				REG_IMAGE_WIDTH:   iw_q <= cfg_data[IW_W-1:0];
				REG_IMAGE_HEIGHT:  ih_q <= cfg_data[IH_W-1:0];
				REG_CHANNEL_COUNT: cc_q <= cfg_data[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_known = cfg_valid && (cfg_index == REG_BLOCK_FACTOR ||
		cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
		cfg_index == REG_CHANNEL_COUNT);

	// zero reads as one, oversize saturates
	assign n = (bf_q == '0) ? FACT_W'(1) :
		(32'(bf_q) > MAX_FACTOR) ? FACT_W'(MAX_FACTOR) : FACT_W'(bf_q);
	assign w = (iw_q == '0) ? COL_EXT_W'(1) :
		(32'(iw_q) > MAX_WIDTH) ? COL_EXT_W'(MAX_WIDTH) : COL_EXT_W'(iw_q);
	assign h = (ih_q == '0) ? ROW_EXT_W'(1) :
		(32'(ih_q) > MAX_HEIGHT) ? ROW_EXT_W'(MAX_HEIGHT) : ROW_EXT_W'(ih_q);
	assign c = (cc_q == '0) ? CC_W'(1) :
		(32'(cc_q) > MAX_CHANNELS) ? CC_W'(MAX_CHANNELS) : CC_W'(cc_q);

	assign last_ch  = (CC_W'(ch_q) + CC_W'(1)) >= c;
	assign last_col = (COL_EXT_W'(col_q) + COL_EXT_W'(1)) >= w;
	assign last_row = (ROW_EXT_W'(row_q) + ROW_EXT_W'(1)) >= h;
	assign last_cib = (FACT_W'(cib_q) + FACT_W'(1)) >= n;
	assign last_rib = (FACT_W'(rib_q) + FACT_W'(1)) >= n;

	// block fits if origin + N <= size; it is the last one if origin + 2N > size
	assign col_end   = COL_EXT_W'(col_base_q) + COL_EXT_W'(n);
	assign row_end   = ROW_EXT_W'(row_base_q) + ROW_EXT_W'(n);
	assign whole_col = col_end <= w;
	assign whole_row = row_end <= h;
	assign final_col = (col_end + COL_EXT_W'(n)) > w;
	assign final_row = (row_end + ROW_EXT_W'(n)) > h;

	assign flags.first = (cib_q == '0) && (rib_q == '0);
	assign flags.whole = whole_col && whole_row;
	assign flags.emit  = whole_col && whole_row && last_cib && last_rib;
	assign flags.done  = final_col && final_row && last_ch;

	assign addr = band_q + ADDR_W'(ch_q);
	assign ch   = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= '0;
			col_q      <= '0;
			col_base_q <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			band_q     <= '0;
		end else if (cfg_known) begin
			ch_q       <= '0;
			col_q      <= '0;
			col_base_q <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			cib_q      <= '0;
			rib_q      <= '0;
			band_q     <= '0;
		end else if (advance) begin
			if (!last_ch) begin
				ch_q <= ch_q + CH_W'(1);
			end else begin
				ch_q <= '0;
				if (!last_col) begin
					col_q <= col_q + COL_W'(1);
					if (last_cib) begin
						cib_q      <= '0;
						col_base_q <= col_base_q + COL_W'(n);
						band_q     <= band_q + ADDR_W'(MAX_CHANNELS);
					end else begin
						cib_q <= cib_q + CIB_W'(1);
					end
				end else begin
					col_q      <= '0;
					cib_q      <= '0;
					col_base_q <= '0;
					band_q     <= '0;
					if (!last_row) begin
						row_q <= row_q + ROW_W'(1);
						if (last_rib) begin
							rib_q      <= '0;
							row_base_q <= row_base_q + ROW_W'(n);
						end else begin
							rib_q <= rib_q + CIB_W'(1);
						end
					end else begin
						row_q      <= '0;
						rib_q      <= '0;
						row_base_q <= '0;
					end
				end
			end
		end
	end

endmodule

### rtl/bfd_dp.sv
// ----------------------------------------------------------------------------
// bfd_dp: band-sum memory, restoring divider and output register
// Read-modify-write of one band sum per sample; a closing sample runs the
// rounded sum through a one-bit-per-cycle divider by N*N.
// ----------------------------------------------------------------------------
module bfd_dp import bfd_pkg::*; #(
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS),
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	localparam int FACT_W = $clog2(MAX_FACTOR + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [ADDR_W-1:0]      addr,
	input  logic [CH_W-1:0]        ch,
	input  logic [FACT_W-1:0]      n,
	input  pos_flags_t             flags,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] average,
	output logic [CHAN_OUT_W-1:0]  channel,
	output logic                   frame_done
);

	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR);
	localparam int AREA_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
	localparam int DCNT_W = $clog2(SUM_W);

	logic [SUM_W-1:0] band_mem [DEPTH];

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [CH_W-1:0]        ch_q;
	pos_flags_t             flags_q;
	logic [SUM_W-1:0]       rd_q;
	logic [AREA_W-1:0]      area_q;
	logic [SUM_W-1:0]       dq_q;
	logic [AREA_W-1:0]      rem_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [CHAN_OUT_W-1:0]  chan_q;
	logic                   last_q;
	logic                   ov_q;

	logic [SUM_W-1:0]  sum;
	logic [AREA_W:0]   trial;
	logic              fits;

	assign sum = flags_q.first ? SUM_W'(sample_q) : rd_q + SUM_W'(sample_q);

	// band sums: read on capture, written back in the cycle after
	always_ff @(posedge clk) begin
		if (cmd.capture)
			rd_q <= band_mem[addr];
		if (cmd.acc && flags_q.whole)
			band_mem[addr_q] <= sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
			addr_q   <= addr;
			ch_q     <= ch;
		end
		area_q <= AREA_W'(n) * AREA_W'(n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flags_q <= '0;
		else if (cmd.capture)
			flags_q <= flags;
	end

	// restoring division, quotient bits shift in behind the dividend
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, area_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.acc) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			dq_q  <= sum + SUM_W'(area_q >> 1);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? AREA_W'(trial - {1'b0, area_q}) : AREA_W'(trial);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q  <= dq_q[SAMPLE_BITS-1:0];
			chan_q <= CHAN_OUT_W'(ch_q);
			last_q <= flags_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.load_out)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	assign status.emit     = flags_q.emit;
	assign status.div_last = dcnt_q == DCNT_W'(SUM_W - 1);
	assign status.out_busy = ov_q && !out_ready;

	assign out_valid  = ov_q;
	assign average    = avg_q;
	assign channel    = chan_q;
	assign frame_done = last_q;

endmodule

### rtl/bfd_ctrl.sv
// ----------------------------------------------------------------------------
// bfd_ctrl: sequencing of one sample through the datapath
// Capture and read, accumulate and write back, optional divide, then hand
// the result to the output register.
// ----------------------------------------------------------------------------
module bfd_ctrl import bfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_ACC;
			ST_ACC:  state_d = status.emit ? ST_DIV : ST_IDLE;
			ST_DIV:  if (status.div_last) state_d = ST_OUT;
			ST_OUT:  if (!status.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready     = state_q == ST_IDLE;
	assign cmd.capture  = (state_q == ST_IDLE) && in_valid;
	assign cmd.acc      = state_q == ST_ACC;
	assign cmd.div_step = state_q == ST_DIV;
	assign cmd.load_out = (state_q == ST_OUT) && !status.out_busy;

endmodule

### rtl/box_filter_downsample_core.sv
// ----------------------------------------------------------------------------
// box_filter_downsample_core: N x N box filter downsampler
// Averages each whole N by N block of an interleaved raster stream per
// channel, with rounding to nearest, ties up.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   s_tdata: sample
//   m_*       out        m_tvalid / m_tready   m_tdata: average, m_tuser: channel,
//                                              m_tlast: frame_done
//   cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample passes through a band-sum read on acceptance, then an add and write back
// on the next cycle, through the single-ported band-sum memory.
// A sample that closes a block then runs the bit-serial divide by N*N over SUM_W
// quotient bits (SUM_W = SAMPLE_BITS + 2*clog2(MAX_FACTOR), 24 by default).
// The result then waits in the output register; a new sample is accepted
// while it waits, but a second result holds the block until the first leaves.
// Reset clears registers and position counters; band sums need no clearing.
// ----------------------------------------------------------------------------
module box_filter_downsample_core import bfd_pkg::*; #(
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] average
	output logic [CHAN_OUT_W-1:0] m_tuser,   // [1:0] channel
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS);
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int FACT_W = $clog2(MAX_FACTOR + 1);

	logic [ADDR_W-1:0]      addr;
	logic [CH_W-1:0]        ch;
	logic [FACT_W-1:0]      n;
	pos_flags_t             flags;
	ctrl_cmd_t              cmd;
	dp_status_t             status;
	logic [SAMPLE_BITS-1:0] average;

	assign cfg_ready = 1'b1;

	bfd_pos #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_FACTOR   (MAX_FACTOR)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (cmd.capture),
		.addr      (addr),
		.ch        (ch),
		.n         (n),
		.flags     (flags)
	);

	bfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bfd_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_FACTOR   (MAX_FACTOR)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample     (s_tdata[SAMPLE_BITS-1:0]),
		.addr       (addr),
		.ch         (ch),
		.n          (n),
		.flags      (flags),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.average    (average),
		.channel    (m_tuser),
		.frame_done (m_tlast)
	);

	assign m_tdata = TDATA_W'(average);

endmodule

### rtl/bfd_chk.sv
// ----------------------------------------------------------------------------
// bfd_chk: port-level checks for the box filter downsampler
// Watches the stream and configuration ports; attached to the core by bind.
// ----------------------------------------------------------------------------
module bfd_chk import bfd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [TDATA_W-1:0]    m_tdata,
	input logic [CHAN_OUT_W-1:0] m_tuser,
	input logic                  m_tlast,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one sample in flight: no transaction on the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// a result needs the divide, so it never shows right after an input
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too soon after input transaction");

	// register writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind box_filter_downsample_core bfd_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_bfd_chk (.*);

### test/box_filter_downsample_core_test.sv
// ----------------------------------------------------------------------------
// box_filter_downsample_core_test: self-checking bench for the box filter
// downsampler. Streams interleaved raster frames under many register
// settings and predicts every block mean, its channel and the frame-done
// flag. Each result is compared in arrival order. The sender idles in bursts
// and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module box_filter_downsample_core_test;
	import bfd_pkg::*;

	localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
	localparam int DATA_W        = ((SAMPLE_W + 7) / 8) * 8;
	localparam int FACTOR_MAX    = DEF_MAX_FACTOR;
	localparam int WIDTH_MAX     = DEF_MAX_WIDTH;
	localparam int CHAN_MAX      = DEF_MAX_CHANNELS;
	localparam int SUM_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
	localparam int CFG_DATA_MAX  = (1 << CFG_DATA_W) - 1;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 180;
	localparam int RANDOM_MEANS  = 48;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = '1;

	typedef enum int {FILL_UNIFORM, FILL_FULL_SCALE, FILL_EXTREMES, FILL_LOW_BITS} fill_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]   average;
		logic [CHAN_OUT_W-1:0] channel;
		logic                  frame_done;
	} block_mean_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata   = '0;   // [15:0] sample
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [DATA_W-1:0]     m_tdata;          // [15:0] average
	logic [CHAN_OUT_W-1:0] m_tuser;          // [1:0] channel
	logic                  m_tlast;          // frame_done
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predicted register contents and position counters
	logic [BF_W-1:0]   factor_reg   = RST_BLOCK_FACTOR;
	logic [IW_W-1:0]   width_reg    = RST_IMAGE_WIDTH;
	logic [IH_W-1:0]   height_reg   = RST_IMAGE_HEIGHT;
	logic [CCNT_W-1:0] channels_reg = RST_CHANNEL_COUNT;
	int unsigned band_sum [SUM_DEPTH];
	int unsigned col_pos, row_pos, chan_pos, col_in_blk, row_in_blk;

	block_mean_t expected_means [$];
	block_mean_t front_mean;
	int unsigned means_predicted;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned gap_max = 3;
	logic [7:0]  ready_pattern = 8'hFF;
	logic [6:0]  ready_phase   = '0;

	box_filter_downsample_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_cfg(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	function automatic void restart_position();
		col_pos    = 0;
		row_pos    = 0;
		chan_pos   = 0;
		col_in_blk = 0;
		row_in_blk = 0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		case (index)
		REG_BLOCK_FACTOR:  factor_reg   = value[BF_W-1:0];
		REG_IMAGE_WIDTH:   width_reg    = value[IW_W-1:0];
		REG_IMAGE_HEIGHT:  height_reg   = value[IH_W-1:0];
		REG_CHANNEL_COUNT: channels_reg = value[CCNT_W-1:0];
		default:           return;
		endcase
		restart_position();
	endfunction

	// one accepted sample: update the band sum, queue a mean when a block closes
	function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value);
		int unsigned n, w, h, c, out_w, out_h, blk_col, blk_row, idx, area;
		bit last_ch, last_col, last_row, last_cib, last_rib;
		block_mean_t mean;
		n        = clamp_cfg(factor_reg, FACTOR_MAX);
		w        = clamp_cfg(width_reg, WIDTH_MAX);
		h        = clamp_cfg(height_reg, MAX_HEIGHT);
		c        = clamp_cfg(channels_reg, CHAN_MAX);
		out_w    = w / n;
		out_h    = h / n;
		blk_col  = col_pos / n;
		blk_row  = row_pos / n;
		last_ch  = chan_pos + 1 >= c;
		last_col = col_pos + 1 >= w;
		last_row = row_pos + 1 >= h;
		last_cib = col_in_blk + 1 >= n;
		last_rib = row_in_blk + 1 >= n;
		if (blk_col < out_w && blk_row < out_h && chan_pos < c) begin
			idx = blk_col * CHAN_MAX + chan_pos;
			if (col_in_blk == 0 && row_in_blk == 0)
				band_sum[idx] = value;
			else
				band_sum[idx] += value;
			if (last_cib && last_rib) begin
				area             = n * n;
				mean.average     = SAMPLE_W'((band_sum[idx] + area / 2) / area);
				mean.channel     = CHAN_OUT_W'(chan_pos);
				mean.frame_done  = blk_col + 1 == out_w && blk_row + 1 == out_h && last_ch;
				expected_means.push_back(mean);
				means_predicted++;
			end
		end
		if (!last_ch) begin
			chan_pos++;
		end else begin
			chan_pos = 0;
			if (!last_col) begin
				col_pos++;
				col_in_blk = last_cib ? 0 : col_in_blk + 1;
			end else begin
				col_pos    = 0;
				col_in_blk = 0;
				if (!last_row) begin
					row_pos++;
					row_in_blk = last_rib ? 0 : row_in_blk + 1;
				end else begin
					row_pos    = 0;
					row_in_blk = 0;
				end
			end
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_t fill);
		case (fill)
		FILL_FULL_SCALE: return SAMPLE_W'(SAMPLE_MAX);
		FILL_EXTREMES:   return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
		FILL_LOW_BITS:   return SAMPLE_W'($urandom_range(0, 3));
		default:         return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
			cycle_count, what, got, want);
		error_count++;
	endtask

	// called and returns at a falling edge; s_tvalid stays high between calls
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int unsigned gap;
		if (gap_max != 0 && burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(value);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accumulate_sample(value);
		if (burst_left != 0)
			burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// all results out, then time for a sample still in flight or dividing
	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after its last write
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(index, value);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned bf, input int unsigned w,
			input int unsigned h, input int unsigned c);
		logic [CFG_IDX_W-1:0]  regs [4];
		logic [CFG_DATA_W-1:0] values [4];
		int unsigned first;
		regs   = '{REG_BLOCK_FACTOR, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CHANNEL_COUNT};
		values = '{CFG_DATA_W'(bf), CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(c)};
		first  = $urandom_range(0, 3);
		settle();
		if ($urandom_range(0, 3) == 0)
			write_register(REG_UNMAPPED_HIGH, CFG_DATA_W'($urandom));
		for (int k = 0; k < 4; k++)
			write_register(regs[(first + k) % 4], values[(first + k) % 4]);
		cfg_valid <= 1'b0;
	endtask

	// reset frame is far too large to finish; samples only prime band sums
	task automatic test_large_frame();
		repeat (6) send_sample(pick_sample(FILL_UNIFORM));
		configure(FACTOR_MAX, WIDTH_MAX, MAX_HEIGHT, CHAN_MAX);
		repeat (6) send_sample(pick_sample(FILL_UNIFORM));
	endtask

	task automatic test_register_limits();
		configure(1, 1, 1, 1);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(SAMPLE_W'(16'h5555));
		send_sample(SAMPLE_W'(16'hAAAA));
		// zero in each register reads as one
		configure(0, 0, 0, 0);
		repeat (2) send_sample(pick_sample(FILL_UNIFORM));
		configure(1, 1, 1, 7);
		repeat (4) send_sample(pick_sample(FILL_UNIFORM));
		configure(1, CFG_DATA_MAX, 1, 1);
		repeat (3) send_sample(pick_sample(FILL_UNIFORM));
		configure(1, 1, CFG_DATA_MAX, 1);
		repeat (3) send_sample(pick_sample(FILL_UNIFORM));
	endtask

	task automatic test_rounding();
		configure(2, 2, 2, 1);
		// half way rounds up
		send_sample(16'd0); send_sample(16'd1); send_sample(16'd1); send_sample(16'd0);
		send_sample(16'd3); send_sample(16'd0); send_sample(16'd0); send_sample(16'd0);
		send_sample(16'd1); send_sample(16'd0); send_sample(16'd0); send_sample(16'd0);
		repeat (4) send_sample(SAMPLE_W'(SAMPLE_MAX));
	endtask

	task automatic test_position_restart();
		configure(2, 2, 2, 1);
		repeat (2) send_sample(pick_sample(FILL_UNIFORM));
		// unmapped index keeps the frame position
		settle();
		write_register(REG_UNMAPPED_LOW, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		repeat (2) send_sample(pick_sample(FILL_UNIFORM));
		// a mapped write restarts the frame even with an unchanged value
		repeat (2) send_sample(pick_sample(FILL_UNIFORM));
		settle();
		write_register(REG_CHANNEL_COUNT, CFG_DATA_W'(1));
		cfg_valid <= 1'b0;
		repeat (4) send_sample(pick_sample(FILL_UNIFORM));
		// image smaller than one block: everything dropped
		configure(4, 3, 3, 2);
		repeat (18) send_sample(pick_sample(FILL_UNIFORM));
	endtask

	task automatic test_largest_block();
		// 5-bit field takes 31, which saturates to the largest factor
		configure(CFG_DATA_MAX, FACTOR_MAX, FACTOR_MAX, 1);
		repeat (FACTOR_MAX * FACTOR_MAX) send_sample(pick_sample(FILL_UNIFORM));
	endtask

	task automatic test_random_frames();
		int unsigned n, w, h, c, r, frame_items, item_total, sent, means_start;
		fill_t fill;
		sent        = 0;
		means_start = means_predicted;
		while (sent < RANDOM_ITEMS || means_predicted - means_start < RANDOM_MEANS) begin
			r = $urandom_range(0, 9);
			n = (r < 3) ? 1 : (r < 7) ? 2 : (r < 9) ? $urandom_range(3, 5) : $urandom_range(6, 8);
			c = $urandom_range(1, CHAN_MAX);
			w = $urandom_range(1, 3 * n + 1);
			h = $urandom_range(1, 2 * n + 1);
			while (w * h * c > 160 && h > 1)
				h--;
			while (w * h * c > 160 && w > 1)
				w--;
			frame_items = w * h * c;
			item_total  = frame_items * $urandom_range(1, 3);
			// cut a frame short now and then
			if ($urandom_range(0, 3) == 0)
				item_total += $urandom_range(1, frame_items);
			fill = fill_t'($urandom_range(0, 3));
			configure(n, w, h, c);
			r       = $urandom_range(0, 3);
			gap_max = (r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 6 : 20;
			for (int k = 0; k < item_total; k++) begin
				send_sample(pick_sample(($urandom_range(0, 9) == 0) ? FILL_UNIFORM : fill));
				sent++;
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
		end
	endtask

	// receiver: 8-bit ready pattern indexed by the low phase bits, redrawn each time the 7-bit phase counter wraps
	always @(negedge clk) begin
		ready_phase <= ready_phase + 1'b1;
		if (ready_phase == '0)
			ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		m_tready <= ready_pattern[ready_phase[2:0]];
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_means.size() == 0) begin
				report_mismatch("unexpected transaction, average", m_tdata, 0);
			end else begin
				front_mean = expected_means.pop_front();
				if (m_tdata[SAMPLE_W-1:0] !== front_mean.average)
					report_mismatch("average", m_tdata[SAMPLE_W-1:0], front_mean.average);
				if (m_tuser !== front_mean.channel)
					report_mismatch("channel", m_tuser, front_mean.channel);
				if (m_tlast !== front_mean.frame_done)
					report_mismatch("frame_done", m_tlast, front_mean.frame_done);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_means.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_large_frame();
		test_register_limits();
		test_rounding();
		test_position_restart();
		test_largest_block();
		test_random_frames();
		if (expected_means.size() != 0)
			$display("final drain, %0d results outstanding", expected_means.size());
		settle();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
